// File: design/qau_pkg.sv
// Shared types, widths, opcodes and stage counts of the quaternion arithmetic unit.
package qau_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // Width of a result component before it is clamped to 32 bits.
  localparam int PW = 68;

  // Register stages of the normalize path and of the axis-angle path.
  localparam int NORM_LAT = 70;
  localparam int TRIG_LAT = 43;

  typedef logic signed [31:0]   fix_t;
  typedef logic signed [PW-1:0] wide_t;

  typedef struct packed {
    fix_t i;
    fix_t j;
    fix_t k;
    fix_t w;
  } quat_t;

  typedef struct packed {
    wide_t i;
    wide_t j;
    wide_t k;
    wide_t w;
  } wquat_t;

  typedef enum logic [2:0] {
    OP_MUL   = 3'd0,
    OP_CONJ  = 3'd1,
    OP_NORM  = 3'd2,
    OP_ROT   = 3'd3,
    OP_ADDV  = 3'd4,
    OP_AXANG = 3'd5
  } opcode_t;

  localparam wide_t FIX_MAX = wide_t'(64'sd2147483647);
  localparam wide_t FIX_MIN = -wide_t'(64'sd2147483648);

endpackage

// File: design/qau_norm.sv
// Normalize path: sum of squares, pipelined square root and four pipelined dividers.
module qau_norm #(
  parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           ce,
  input  qau_pkg::quat_t a,
  output qau_pkg::wquat_t r
);
  import qau_pkg::*;

  localparam int SQ_STEPS = 32;
  localparam int DIV_BITS = 33;

  fix_t        av [4];
  logic [63:0] sq [4];
  quat_t       a1, a2;
  logic [65:0] m;
  logic        ovf;

  logic [63:0] sx [SQ_STEPS+1];
  logic [63:0] sr [SQ_STEPS+1];
  logic        sz [SQ_STEPS+1];
  quat_t       sa [SQ_STEPS+1];

  logic [63:0] dr  [DIV_BITS+1][4];
  logic [32:0] dq  [DIV_BITS+1][4];
  logic        dov [DIV_BITS+1][4];
  logic        dng [DIV_BITS+1][4];
  logic [32:0] ds  [DIV_BITS+1];
  logic        dz  [DIV_BITS+1];
  quat_t       da  [DIV_BITS+1];

  fix_t        fa [4];
  logic [31:0] mag [4];
  logic [63:0] u [4];
  logic [32:0] s_root;
  wide_t       res [4];

  assign av = '{a.i, a.j, a.k, a.w};

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int c = 0; c < 4; c++) begin
        sq[c] <= 64'(av[c] * av[c]);
      end
      a1 <= a;
      m  <= 66'(sq[0] >> FRAC_BITS) + 66'(sq[1] >> FRAC_BITS)
          + 66'(sq[2] >> FRAC_BITS) + 66'(sq[3] >> FRAC_BITS);
      a2 <= a1;
    end
  end

  assign ovf = |(m >> (64 - FRAC_BITS));

  always_ff @(posedge clk) begin
    if (ce) begin
      sx[0] <= ovf ? '1 : 64'(m << FRAC_BITS);
      sr[0] <= '0;
      sz[0] <= (m == '0);
      sa[0] <= a2;
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    always_ff @(posedge clk) begin
      if (ce) begin
        if (sx[k] >= sr[k] + BIT) begin
          sx[k+1] <= sx[k] - (sr[k] + BIT);
          sr[k+1] <= (sr[k] >> 1) + BIT;
        end else begin
          sx[k+1] <= sx[k];
          sr[k+1] <= sr[k] >> 1;
        end
        sz[k+1] <= sz[k];
        sa[k+1] <= sa[k];
      end
    end
  end

  assign s_root = 33'(sr[SQ_STEPS]);
  assign fa = '{sa[SQ_STEPS].i, sa[SQ_STEPS].j, sa[SQ_STEPS].k, sa[SQ_STEPS].w};

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      mag[c] = fa[c][31] ? 32'(-fa[c]) : 32'(fa[c]);
      u[c]   = 64'(mag[c]) << FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int c = 0; c < 4; c++) begin
        dr[0][c]  <= u[c];
        dq[0][c]  <= '0;
        dov[0][c] <= {2'b00, u[c]} >= (66'(s_root) << DIV_BITS);
        dng[0][c] <= fa[c][31];
      end
      ds[0] <= s_root;
      dz[0] <= sz[SQ_STEPS];
      da[0] <= sa[SQ_STEPS];
    end
  end

  for (genvar n = 0; n < DIV_BITS; n++) begin : g_div
    localparam int B = DIV_BITS - 1 - n;
    logic [65:0] dsh;
    assign dsh = 66'(ds[n]) << B;
    always_ff @(posedge clk) begin
      if (ce) begin
        for (int c = 0; c < 4; c++) begin
          if ({2'b00, dr[n][c]} >= dsh) begin
            dr[n+1][c] <= 64'({2'b00, dr[n][c]} - dsh);
            dq[n+1][c] <= dq[n][c] | (33'd1 << B);
          end else begin
            dr[n+1][c] <= dr[n][c];
            dq[n+1][c] <= dq[n][c];
          end
          dov[n+1][c] <= dov[n][c];
          dng[n+1][c] <= dng[n][c];
        end
        ds[n+1] <= ds[n];
        dz[n+1] <= dz[n];
        da[n+1] <= da[n];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      if (dov[DIV_BITS][c]) begin
        res[c] = dng[DIV_BITS][c] ? -(wide_t'(1) << 40) : (wide_t'(1) << 40);
      end else if (dng[DIV_BITS][c]) begin
        res[c] = -(wide_t'(dq[DIV_BITS][c]) + wide_t'(dr[DIV_BITS][c] != '0));
      end else begin
        res[c] = wide_t'(dq[DIV_BITS][c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      if (dz[DIV_BITS]) begin
        r.i <= wide_t'(da[DIV_BITS].i);
        r.j <= wide_t'(da[DIV_BITS].j);
        r.k <= wide_t'(da[DIV_BITS].k);
        r.w <= wide_t'(1) << FRAC_BITS;
      end else begin
        r.i <= res[0];
        r.j <= res[1];
        r.k <= res[2];
        r.w <= res[3];
      end
    end
  end

endmodule

// File: design/qau_trig.sv
// Axis-angle path: angle reduction, sine and cosine by Horner steps, axis scaling.
module qau_trig #(
  parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            ce,
  input  qau_pkg::fix_t   scalar,
  input  qau_pkg::quat_t  b,
  output qau_pkg::wquat_t r
);
  import qau_pkg::*;

  localparam int RED_STEPS = 21;
  localparam int H_STEPS   = 5;
  localparam int SIDE_LEN  = 3 * H_STEPS + 1;

  localparam logic [63:0]        TWO_PI64 = 64'd6746518852;
  localparam logic signed [35:0] TWO_PI   = 36'sd6746518852;
  localparam logic signed [35:0] PI       = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI  = 36'sd1686629713;
  localparam logic signed [35:0] QTR_PI   = 36'sd843314857;
  localparam logic [30:0]        ONE30    = 31'd1 << 30;

  localparam int COS_DIV [H_STEPS] = '{90, 56, 30, 12, 2};
  localparam int SIN_DIV [H_STEPS-1] = '{72, 42, 20, 6};

  typedef struct packed {
    quat_t              b;
    logic signed [31:0] t;
    logic [29:0]        x2;
    logic               sw;
    logic               ng;
    logic               cn;
  } side_t;

  logic signed [63:0] h;
  logic [63:0]        gu [RED_STEPS+1];
  logic               gn [RED_STEPS+1];
  quat_t              gb [RED_STEPS+1];

  logic signed [35:0] x1, f1_x, xv, tv;
  logic               cn, sw, ng;
  quat_t              f1_b, f2_b;
  logic signed [31:0] f2_t;
  logic               f2_sw, f2_ng, f2_cn;
  logic signed [63:0] tt;

  side_t              side [SIDE_LEN];
  logic [30:0]        ct [1:H_STEPS];
  logic [30:0]        st [1:H_STEPS-1];
  logic signed [31:0] sfin;

  logic signed [31:0] sv, cv, s_sel, c_sel;
  logic signed [31:0] ps, pc, pc2;
  quat_t              p1_b;
  logic signed [63:0] pp [3];

  assign h = (64'(scalar) <<< (30 - FRAC_BITS)) >>> 1;

  always_ff @(posedge clk) begin
    if (ce) begin
      gn[0] <= h[63];
      gu[0] <= h[63] ? 64'(-h) : 64'(h);
      gb[0] <= b;
    end
  end

  for (genvar n = 0; n < RED_STEPS; n++) begin : g_red
    localparam logic [63:0] CK = TWO_PI64 << (RED_STEPS - 1 - n);
    always_ff @(posedge clk) begin
      if (ce) begin
        gu[n+1] <= (gu[n] >= CK) ? gu[n] - CK : gu[n];
        gn[n+1] <= gn[n];
        gb[n+1] <= gb[n];
      end
    end
  end

  always_comb begin
    if (gn[RED_STEPS]) begin
      x1 = (gu[RED_STEPS] == '0) ? '0 : TWO_PI - 36'(gu[RED_STEPS]);
    end else begin
      x1 = 36'(gu[RED_STEPS]);
    end
    if (x1 > PI) begin
      x1 = x1 - TWO_PI;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      f1_x <= x1;
      f1_b <= gb[RED_STEPS];
    end
  end

  always_comb begin
    xv = f1_x;
    cn = 1'b0;
    if (f1_x > HALF_PI) begin
      xv = PI - f1_x;
      cn = 1'b1;
    end else if (f1_x < -HALF_PI) begin
      xv = -PI - f1_x;
      cn = 1'b1;
    end
    if (xv > QTR_PI) begin
      tv = HALF_PI - xv;
      sw = 1'b1;
      ng = 1'b0;
    end else if (xv < -QTR_PI) begin
      tv = -HALF_PI - xv;
      sw = 1'b1;
      ng = 1'b1;
    end else begin
      tv = xv;
      sw = 1'b0;
      ng = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      f2_t  <= 32'(tv);
      f2_sw <= sw;
      f2_ng <= ng;
      f2_cn <= cn;
      f2_b  <= f1_b;
    end
  end

  assign tt = f2_t * f2_t;

  always_ff @(posedge clk) begin
    if (ce) begin
      side[0].b  <= f2_b;
      side[0].t  <= f2_t;
      side[0].x2 <= 30'(tt >>> 30);
      side[0].sw <= f2_sw;
      side[0].ng <= f2_ng;
      side[0].cn <= f2_cn;
    end
  end

  for (genvar n = 1; n < SIDE_LEN; n++) begin : g_side
    always_ff @(posedge clk) begin
      if (ce) begin
        side[n] <= side[n-1];
      end
    end
  end

  for (genvar j = 0; j < H_STEPS; j++) begin : g_cos
    localparam logic [30:0] CD = 31'(COS_DIV[j]);
    localparam logic [31:0] CR = 32'(64'd4294967296 / COS_DIV[j]);
    logic [30:0] cin;
    logic [60:0] pa;
    logic [29:0] vb, vtmp, q0;
    logic [61:0] mb;
    logic [30:0] rem, q;
    if (j == 0) begin : g_first
      assign cin = ONE30;
    end else begin : g_next
      assign cin = ct[j];
    end
    assign vtmp = 30'(pa >> 30);
    assign q0   = 30'(mb >> 32);
    assign rem  = {1'b0, vb} - 31'(q0 * CD);
    assign q    = (rem >= CD) ? 31'(q0) + 31'd1 : 31'(q0);
    always_ff @(posedge clk) begin
      if (ce) begin
        pa        <= side[3*j].x2 * cin;
        vb        <= vtmp;
        mb        <= vtmp * CR;
        ct[j+1]   <= ONE30 - q;
      end
    end
  end

  for (genvar j = 0; j < H_STEPS; j++) begin : g_sin
    if (j < H_STEPS - 1) begin : g_step
      localparam logic [30:0] SD = 31'(SIN_DIV[j]);
      localparam logic [31:0] SR = 32'(64'd4294967296 / SIN_DIV[j]);
      logic [30:0] sin_in;
      logic [60:0] pa;
      logic [29:0] vb, vtmp, q0;
      logic [61:0] mb;
      logic [30:0] rem, q;
      if (j == 0) begin : g_first
        assign sin_in = ONE30;
      end else begin : g_next
        assign sin_in = st[j];
      end
      assign vtmp = 30'(pa >> 30);
      assign q0   = 30'(mb >> 32);
      assign rem  = {1'b0, vb} - 31'(q0 * SD);
      assign q    = (rem >= SD) ? 31'(q0) + 31'd1 : 31'(q0);
      always_ff @(posedge clk) begin
        if (ce) begin
          pa      <= side[3*j].x2 * sin_in;
          vb      <= vtmp;
          mb      <= vtmp * SR;
          st[j+1] <= ONE30 - q;
        end
      end
    end else begin : g_final
      logic signed [63:0] pa;
      logic signed [31:0] vb;
      always_ff @(posedge clk) begin
        if (ce) begin
          pa   <= side[3*j].t * $signed({1'b0, st[j]});
          vb   <= 32'(pa >>> 30);
          sfin <= vb;
        end
      end
    end
  end

  always_comb begin
    sv = sfin;
    cv = $signed({1'b0, ct[H_STEPS]});
    s_sel = side[SIDE_LEN-1].sw ? cv : sv;
    c_sel = side[SIDE_LEN-1].sw ? sv : cv;
    if (side[SIDE_LEN-1].ng) begin
      s_sel = -s_sel;
      c_sel = -c_sel;
    end
    if (side[SIDE_LEN-1].cn) begin
      c_sel = -c_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ps    <= s_sel >>> (30 - FRAC_BITS);
      pc    <= c_sel >>> (30 - FRAC_BITS);
      p1_b  <= side[SIDE_LEN-1].b;
      pp[0] <= p1_b.i * ps;
      pp[1] <= p1_b.j * ps;
      pp[2] <= p1_b.k * ps;
      pc2   <= pc;
      r.i   <= wide_t'(pp[0] >>> FRAC_BITS);
      r.j   <= wide_t'(pp[1] >>> FRAC_BITS);
      r.k   <= wide_t'(pp[2] >>> FRAC_BITS);
      r.w   <= wide_t'(pc2);
    end
  end

endmodule

// File: design/quaternion_arithmetic_unit_top.sv
// Top level of the quaternion arithmetic unit: handshake, product path, alignment, clamping.
//
// The unit takes one request per cycle on the slave stream while the output is not held and
// returns one quaternion per request on the master stream, in the order of the requests.
// s_tuser carries the opcode; s_tdata carries quaternion A, quaternion or vector B and the
// scalar. All values are signed fixed point with FRAC_BITS fraction bits.
// Every request passes through the same 71 register stages, whatever its opcode, and the
// throughput is one request per cycle while the output is not held. The longest path is
// the normalize chain: a 32-stage square root followed by 33-stage dividers. The other
// paths are delayed to meet it.
// The whole pipeline advances together. When m_tvalid is high and m_tready is low, every
// stage holds and s_tready falls; no request is lost or repeated. Empty stages do not
// compress while the output is held.
// Reset clears the valid bits of all stages; the data registers are not reset.
module quaternion_arithmetic_unit_top #(
  parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // a_i, a_j, a_k, a_w, b_i, b_j, b_k, b_w, scalar (32 bits each)
  input  logic [287:0] s_tdata,
  // opcode
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // r_i, r_j, r_k, r_w (32 bits each)
  output logic [127:0] m_tdata,
  // saturated
  output logic [0:0]   m_tuser
);
  import qau_pkg::*;

  localparam int HAM_LAT  = 5;
  localparam int CORE_LAT = NORM_LAT;
  localparam int LAT      = CORE_LAT + 1;
  localparam int HAM_PAD  = CORE_LAT - HAM_LAT;
  localparam int TRIG_PAD = CORE_LAT - TRIG_LAT;

  function automatic logic [32:0] sat32(input wide_t v);
    if (v > FIX_MAX) begin
      return {1'b1, 32'h7fffffff};
    end else if (v < FIX_MIN) begin
      return {1'b1, 32'h80000000};
    end
    return {1'b0, v[31:0]};
  endfunction

  logic               ce;
  logic [LAT-1:0]     vld;
  quat_t              a_in, b_in;
  fix_t               sc_in;
  opcode_t            op_d [CORE_LAT];

  quat_t              h1_a, h1_b, h2_a, h3_a, h4_a;
  logic signed [63:0] h1_pv [3];
  logic [32:0]        vs [3];
  quat_t              h2_l, h2_r;
  logic               h2_vf, h3_vf, h4_vf;
  fix_t               lv [4];
  fix_t               rv [4];
  logic signed [63:0] h3_pp [16];
  wide_t              mq [16];
  wquat_t             h4_q;
  wquat_t             ham_d [HAM_PAD];
  logic               hamf_d [HAM_PAD];
  wquat_t             h5_r;
  logic               h5_f;

  wquat_t             nrm_r, trg_r;
  wquat_t             trg_d [TRIG_PAD];

  wquat_t             fin;
  logic               fin_f;
  logic [32:0]        so [4];

  assign ce       = ~vld[LAT-1] | m_tready;
  assign s_tready = ce;
  assign m_tvalid = vld[LAT-1];

  assign a_in  = '{i: s_tdata[31:0],    j: s_tdata[63:32],
                   k: s_tdata[95:64],   w: s_tdata[127:96]};
  assign b_in  = '{i: s_tdata[159:128], j: s_tdata[191:160],
                   k: s_tdata[223:192], w: s_tdata[255:224]};
  assign sc_in = s_tdata[287:256];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      op_d[0] <= opcode_t'(s_tuser);
      for (int n = 1; n < CORE_LAT; n++) begin
        op_d[n] <= op_d[n-1];
      end
    end
  end

  // Product path: scaled vector, operand selection, sixteen products, sums.
  always_ff @(posedge clk) begin
    if (ce) begin
      h1_a     <= a_in;
      h1_b     <= b_in;
      h1_pv[0] <= sc_in * b_in.i;
      h1_pv[1] <= sc_in * b_in.j;
      h1_pv[2] <= sc_in * b_in.k;
    end
  end

  always_comb begin
    for (int n = 0; n < 3; n++) begin
      vs[n] = sat32(wide_t'(h1_pv[n] >>> FRAC_BITS));
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      h2_a  <= h1_a;
      unique case (op_d[0])
        OP_ADDV: begin
          h2_l  <= '{i: vs[0][31:0], j: vs[1][31:0], k: vs[2][31:0], w: '0};
          h2_r  <= h1_a;
          h2_vf <= vs[0][32] | vs[1][32] | vs[2][32];
        end
        OP_ROT: begin
          h2_l  <= h1_a;
          h2_r  <= '{i: h1_b.i, j: h1_b.j, k: h1_b.k, w: '0};
          h2_vf <= 1'b0;
        end
        default: begin
          h2_l  <= h1_a;
          h2_r  <= h1_b;
          h2_vf <= 1'b0;
        end
      endcase
    end
  end

  assign lv = '{h2_l.w, h2_l.i, h2_l.j, h2_l.k};
  assign rv = '{h2_r.w, h2_r.i, h2_r.j, h2_r.k};

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int x = 0; x < 4; x++) begin
        for (int y = 0; y < 4; y++) begin
          h3_pp[4*x+y] <= lv[x] * rv[y];
        end
      end
      h3_a  <= h2_a;
      h3_vf <= h2_vf;
    end
  end

  always_comb begin
    for (int n = 0; n < 16; n++) begin
      mq[n] = wide_t'(h3_pp[n] >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      h4_q.i <= mq[1] + mq[4] + mq[11] - mq[14];
      h4_q.j <= mq[2] - mq[7] + mq[8] + mq[13];
      h4_q.k <= mq[3] + mq[6] - mq[9] + mq[12];
      h4_q.w <= mq[0] - mq[5] - mq[10] - mq[15];
      h4_a   <= h3_a;
      h4_vf  <= h3_vf;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      unique case (op_d[3])
        OP_MUL, OP_ROT: begin
          h5_r <= h4_q;
          h5_f <= 1'b0;
        end
        OP_ADDV: begin
          h5_r.i <= wide_t'(h4_a.i) + (h4_q.i >>> 1);
          h5_r.j <= wide_t'(h4_a.j) + (h4_q.j >>> 1);
          h5_r.k <= wide_t'(h4_a.k) + (h4_q.k >>> 1);
          h5_r.w <= wide_t'(h4_a.w) + (h4_q.w >>> 1);
          h5_f   <= h4_vf;
        end
        OP_CONJ: begin
          h5_r.i <= -wide_t'(h4_a.i);
          h5_r.j <= -wide_t'(h4_a.j);
          h5_r.k <= -wide_t'(h4_a.k);
          h5_r.w <= wide_t'(h4_a.w);
          h5_f   <= 1'b0;
        end
        default: begin
          h5_r <= '0;
          h5_f <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ham_d[0]  <= h5_r;
      hamf_d[0] <= h5_f;
      for (int n = 1; n < HAM_PAD; n++) begin
        ham_d[n]  <= ham_d[n-1];
        hamf_d[n] <= hamf_d[n-1];
      end
    end
  end

  qau_norm #(
    .FRAC_BITS (FRAC_BITS)
  ) u_norm (
    .clk (clk),
    .ce  (ce),
    .a   (a_in),
    .r   (nrm_r)
  );

  qau_trig #(
    .FRAC_BITS (FRAC_BITS)
  ) u_trig (
    .clk    (clk),
    .ce     (ce),
    .scalar (sc_in),
    .b      (b_in),
    .r      (trg_r)
  );

  always_ff @(posedge clk) begin
    if (ce) begin
      trg_d[0] <= trg_r;
      for (int n = 1; n < TRIG_PAD; n++) begin
        trg_d[n] <= trg_d[n-1];
      end
    end
  end

  always_comb begin
    fin_f = 1'b0;
    unique case (op_d[CORE_LAT-1])
      OP_NORM: begin
        fin = nrm_r;
      end
      OP_AXANG: begin
        fin = trg_d[TRIG_PAD-1];
      end
      default: begin
        fin   = ham_d[HAM_PAD-1];
        fin_f = hamf_d[HAM_PAD-1];
      end
    endcase
    so[0] = sat32(fin.i);
    so[1] = sat32(fin.j);
    so[2] = sat32(fin.k);
    so[3] = sat32(fin.w);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m_tdata <= {so[3][31:0], so[2][31:0], so[1][31:0], so[0][31:0]};
      m_tuser <= fin_f | so[0][32] | so[1][32] | so[2][32] | so[3][32];
    end
  end

endmodule
